[src/median_filter_3x3_core_defines.svh]
// Assertion helpers shared by the median filter RTL.
// Every check is sampled on the rising clock edge and is off while reset is high.
`ifndef MEDIAN_FILTER_3X3_CORE_DEFINES_SVH
`define MEDIAN_FILTER_3X3_CORE_DEFINES_SVH

// The expression holds at every edge.
`define MF3X3_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define MF3X3_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define MF3X3_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/mf3x3_pkg.sv]
package mf3x3_pkg;

   // Largest frame the line buffers hold.
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   // Field widths.
   localparam int PIX_W  = 16;
   localparam int SIZE_W = 11;

   // Column position addresses the line buffers; rows run up to two past the frame.
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT + 2);

   // Register indexes of the configuration port.
   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   // Frame size after reset.
   localparam int RESET_WIDTH  = 256;
   localparam int RESET_HEIGHT = 256;

   typedef logic [PIX_W-1:0]  pix_type;
   typedef logic [SIZE_W-1:0] size_type;
   typedef logic [COL_W-1:0]  col_type;
   typedef logic [ROW_W-1:0]  row_type;

   // One window column in sorted order.
   typedef struct packed {
      pix_type hi;
      pix_type mid;
      pix_type lo;
   } triple_type;

endpackage

[src/median_filter_3x3_core.sv]
// Channel  Direction  Handshake           Payload
// req      in         req_valid/req_stall req_pixel_in, req_pad
// rsp      out        rsp_valid/rsp_stall rsp_pixel_out, rsp_frame_end
// csr      in         csr_write_en        csr_index, csr_wdata
//
// One transaction is taken every cycle while req does not stall; the two line buffers are
// read once and written once per pixel, and the median network is split over three register
// stages. A result passes through stage 1, stage 2, stage 3 and then the output register.
// Reset clears positions, valids and the frame size to 256 x 256; the line buffers are not
// cleared, and no reset pass is needed.
// A stall on rsp holds the output register; req stalls only when stage 1 holds a pixel with
// a result and stages 2, 3 and the output register are all full behind that stall.
`include "median_filter_3x3_core_defines.svh"

module median_filter_3x3_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  mf3x3_pkg::pix_type           req_pixel_in,
   input  logic                         req_pad,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output mf3x3_pkg::pix_type           rsp_pixel_out,
   output logic                         rsp_frame_end,
   input  logic                         csr_write_en,
   input  logic                         csr_index,
   input  mf3x3_pkg::size_type          csr_wdata
);

   // Compare helpers for the median network.
   function automatic mf3x3_pkg::pix_type pix_min(input mf3x3_pkg::pix_type a,
                                                  input mf3x3_pkg::pix_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic mf3x3_pkg::pix_type pix_max(input mf3x3_pkg::pix_type a,
                                                  input mf3x3_pkg::pix_type b);
      return (a < b) ? b : a;
   endfunction

   function automatic mf3x3_pkg::pix_type med3(input mf3x3_pkg::pix_type a,
                                               input mf3x3_pkg::pix_type b,
                                               input mf3x3_pkg::pix_type c);
      return pix_max(pix_min(a, b), pix_min(pix_max(a, b), c));
   endfunction

   function automatic mf3x3_pkg::triple_type sort3(input mf3x3_pkg::pix_type a,
                                                   input mf3x3_pkg::pix_type b,
                                                   input mf3x3_pkg::pix_type c);
      mf3x3_pkg::pix_type   x_lo;
      mf3x3_pkg::pix_type   x_hi;
      mf3x3_pkg::pix_type   y_lo;
      mf3x3_pkg::triple_type t;
      x_lo  = pix_min(a, b);
      x_hi  = pix_max(a, b);
      y_lo  = pix_min(x_hi, c);
      t.hi  = pix_max(x_hi, c);
      t.lo  = pix_min(x_lo, y_lo);
      t.mid = pix_max(x_lo, y_lo);
      return t;
   endfunction

   // Frame size, held as last column index and row count.
   mf3x3_pkg::col_type w_last_ff, w_last_in;
   mf3x3_pkg::row_type h_ff, h_in;
   mf3x3_pkg::row_type h_plus1;

   // Raster position of the next transaction.
   mf3x3_pkg::col_type col_ff, col_in;
   mf3x3_pkg::row_type row_ff, row_in;

   // Handshake and stage control.
   logic accept;
   logic out_free;
   logic s3_free;
   logic s2_free;
   logic s1_free;
   logic s1_move;

   // Classification of the transaction being accepted.
   logic acc_emit;
   logic acc_last;
   logic acc_interior;
   mf3x3_pkg::pix_type acc_pix;

   // Line buffers with registered reads.
   mf3x3_pkg::pix_type line_prev_mem  [mf3x3_pkg::MAX_WIDTH];
   mf3x3_pkg::pix_type line_prev2_mem [mf3x3_pkg::MAX_WIDTH];
   mf3x3_pkg::pix_type rd_prev_ff;
   mf3x3_pkg::pix_type rd_prev2_ff;

   // Stage 1: pixel waiting for its buffer reads.
   logic               s1_valid_ff;
   logic               s1_emit_ff;
   logic               s1_last_ff;
   logic               s1_interior_ff;
   mf3x3_pkg::col_type s1_col_ff;
   mf3x3_pkg::pix_type s1_pix_ff;
   logic               s1_byp_ff;
   mf3x3_pkg::pix_type s1_byp_prev_ff;
   mf3x3_pkg::pix_type s1_byp_prev2_ff;
   mf3x3_pkg::pix_type s1_prev_eff;
   mf3x3_pkg::pix_type s1_prev2_eff;

   // Two older window columns, row 0 on top.
   mf3x3_pkg::pix_type win_col1_ff [3];
   mf3x3_pkg::pix_type win_col2_ff [3];

   // Stage 2: sorted columns.
   logic                  s2_valid_ff;
   logic                  s2_last_ff;
   logic                  s2_interior_ff;
   mf3x3_pkg::pix_type    s2_center_ff;
   mf3x3_pkg::triple_type s2_col_ff [3];

   // Stage 3: the three candidates of the median.
   logic               s3_valid_ff;
   logic               s3_last_ff;
   logic               s3_interior_ff;
   mf3x3_pkg::pix_type s3_center_ff;
   mf3x3_pkg::pix_type s3_lo_max_ff;
   mf3x3_pkg::pix_type s3_mid_med_ff;
   mf3x3_pkg::pix_type s3_hi_min_ff;

   // Output register.
   logic               rsp_valid_ff;
   logic               rsp_frame_end_ff;
   mf3x3_pkg::pix_type rsp_pixel_ff;

   // Each stage takes a new entry when it is empty or its entry moves on.
   // A pixel that gives no result leaves stage 1 without entering stage 2.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s3_free   = !s3_valid_ff || out_free;
   assign s2_free   = !s2_valid_ff || s3_free;
   assign s1_free   = !s1_valid_ff || !s1_emit_ff || s2_free;
   assign s1_move   = s1_valid_ff && (!s1_emit_ff || s2_free);
   assign req_stall = !s1_free;
   assign accept    = req_valid && !req_stall;

   // A pad counts as a zero pixel.
   assign acc_pix = req_pad ? '0 : req_pixel_in;

   // Results start once a row and one pixel have arrived; the frame ends on the first
   // column of the second flush row, where the bottom right pixel comes out.
   assign h_plus1      = h_ff + mf3x3_pkg::row_type'(1);
   assign acc_emit     = (row_ff >= mf3x3_pkg::row_type'(2)) ||
                         ((row_ff == mf3x3_pkg::row_type'(1)) && (col_ff != '0));
   assign acc_last     = (col_ff == '0) && (row_ff == h_plus1);
   assign acc_interior = (row_ff >= mf3x3_pkg::row_type'(2)) && (row_ff < h_ff) &&
                         (col_ff >= mf3x3_pkg::col_type'(2));

   // Frame size registers; out-of-range sizes are clamped on the write.
   always_comb begin
      w_last_in = w_last_ff;
      h_in      = h_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            mf3x3_pkg::CSR_FRAME_WIDTH: begin
               if (csr_wdata == '0) begin
                  w_last_in = '0;
               end else if (32'(csr_wdata) > mf3x3_pkg::MAX_WIDTH) begin
                  w_last_in = mf3x3_pkg::col_type'(mf3x3_pkg::MAX_WIDTH - 1);
               end else begin
                  w_last_in = mf3x3_pkg::col_type'(csr_wdata - mf3x3_pkg::size_type'(1));
               end
            end
            mf3x3_pkg::CSR_FRAME_HEIGHT: begin
               if (csr_wdata == '0) begin
                  h_in = mf3x3_pkg::row_type'(1);
               end else if (32'(csr_wdata) > mf3x3_pkg::MAX_HEIGHT) begin
                  h_in = mf3x3_pkg::row_type'(mf3x3_pkg::MAX_HEIGHT);
               end else begin
                  h_in = mf3x3_pkg::row_type'(csr_wdata);
               end
            end
         endcase
      end
   end

   // Raster position; a register write or the end of a frame starts over.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_write_en) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (acc_last) begin
            col_in = '0;
            row_in = '0;
         end else if (col_ff == w_last_ff) begin
            col_in = '0;
            row_in = row_ff + mf3x3_pkg::row_type'(1);
         end else begin
            col_in = col_ff + mf3x3_pkg::col_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_last_ff <= mf3x3_pkg::col_type'(mf3x3_pkg::RESET_WIDTH - 1);
         h_ff      <= mf3x3_pkg::row_type'(mf3x3_pkg::RESET_HEIGHT);
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         w_last_ff <= w_last_in;
         h_ff      <= h_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   // Line buffers: read at the accepted column, written when stage 1 moves on.
   always_ff @(posedge clock) begin
      if (s1_move) begin
         line_prev_mem[s1_col_ff]  <= s1_pix_ff;
         line_prev2_mem[s1_col_ff] <= s1_prev_eff;
      end
      if (accept) begin
         rd_prev_ff  <= line_prev_mem[col_ff];
         rd_prev2_ff <= line_prev2_mem[col_ff];
      end
   end

   // A read of the column being written in the same cycle takes the new data.
   assign s1_prev_eff  = s1_byp_ff ? s1_byp_prev_ff  : rd_prev_ff;
   assign s1_prev2_eff = s1_byp_ff ? s1_byp_prev2_ff : rd_prev2_ff;

   // Stage 1 control.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= accept;
      end
   end

   // Stage 1 payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_emit_ff      <= acc_emit;
         s1_last_ff      <= acc_last;
         s1_interior_ff  <= acc_interior;
         s1_col_ff       <= col_ff;
         s1_pix_ff       <= acc_pix;
         s1_byp_ff       <= s1_move && (s1_col_ff == col_ff);
         s1_byp_prev_ff  <= s1_pix_ff;
         s1_byp_prev2_ff <= s1_prev_eff;
      end
   end

   // Window shift once per pixel as it leaves stage 1; column sort whenever stage 2 takes an entry.
   always_ff @(posedge clock) begin
      if (s1_move) begin
         win_col1_ff    <= win_col2_ff;
         win_col2_ff[0] <= s1_prev2_eff;
         win_col2_ff[1] <= s1_prev_eff;
         win_col2_ff[2] <= s1_pix_ff;
      end
      if (s2_free) begin
         s2_col_ff[0]   <= sort3(win_col1_ff[0], win_col1_ff[1], win_col1_ff[2]);
         s2_col_ff[1]   <= sort3(win_col2_ff[0], win_col2_ff[1], win_col2_ff[2]);
         s2_col_ff[2]   <= sort3(s1_prev2_eff, s1_prev_eff, s1_pix_ff);
         s2_center_ff   <= win_col2_ff[1];
         s2_last_ff     <= s1_last_ff;
         s2_interior_ff <= s1_interior_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_move && s1_emit_ff;
      end
   end

   // Stage 3: largest low, median of the middles, smallest high.
   always_ff @(posedge clock) begin
      if (s3_free) begin
         s3_lo_max_ff   <= pix_max(pix_max(s2_col_ff[0].lo, s2_col_ff[1].lo), s2_col_ff[2].lo);
         s3_mid_med_ff  <= med3(s2_col_ff[0].mid, s2_col_ff[1].mid, s2_col_ff[2].mid);
         s3_hi_min_ff   <= pix_min(pix_min(s2_col_ff[0].hi, s2_col_ff[1].hi), s2_col_ff[2].hi);
         s3_center_ff   <= s2_center_ff;
         s3_last_ff     <= s2_last_ff;
         s3_interior_ff <= s2_interior_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_free) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // Output register: the median for interior pixels, the center pixel on the border.
   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_pixel_ff     <= s3_interior_ff ?
                             med3(s3_lo_max_ff, s3_mid_med_ff, s3_hi_min_ff) : s3_center_ff;
         rsp_frame_end_ff <= s3_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

   // Position stays inside the frame and its flush rows.
   `MF3X3_ASSERT_ALWAYS(a_col_in_frame, col_ff <= w_last_ff, "column position beyond frame width")
   `MF3X3_ASSERT_ALWAYS(a_row_in_frame, row_ff <= h_plus1, "row position beyond last flush row")
   // The frame-end transaction restarts the raster position.
   `MF3X3_ASSERT_NXT(a_restart_after_last, accept && acc_last && !csr_write_en,
                     col_ff == '0 && row_ff == '0, "position not cleared after frame end")
   // The input stalls only when every stage holds a result that cannot move.
   `MF3X3_ASSERT_IMP(a_stall_cause, req_stall,
                     s1_valid_ff && s1_emit_ff && s2_valid_ff && s3_valid_ff && !out_free,
                     "input stalled with room in the pipeline")

endmodule
